>>> hw/rtl/two_register_cpu_step_assert.svh
// Assertion macros shared by the two-register CPU step modules.
`ifndef TWO_REGISTER_CPU_STEP_ASSERT_SVH
`define TWO_REGISTER_CPU_STEP_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent.
`define TRCS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

// Consequent must hold in the same cycle as the antecedent.
`define TRCS_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

`endif

>>> hw/rtl/trcs_pkg.sv
// Shared types and constants of the two-register CPU step.
package trcs_pkg;

   localparam int WORD_W      = 16;
   localparam int ADDR_W      = 15;
   localparam int CTRL_W      = 6;
   localparam int QUEUE_DEPTH = 2;

   localparam int BIT_COMPUTE = 15;
   localparam int BIT_USE_MEM = 12;
   localparam int CTRL_LSB    = 6;
   localparam int DEST_LSB    = 3;
   localparam int JUMP_LSB    = 0;

   localparam int DEST_A = 2;
   localparam int DEST_D = 1;
   localparam int DEST_M = 0;

   localparam int JUMP_LT = 2;
   localparam int JUMP_EQ = 1;
   localparam int JUMP_GT = 0;

   localparam int ALU_ZX = 5;
   localparam int ALU_NX = 4;
   localparam int ALU_ZY = 3;
   localparam int ALU_NY = 2;
   localparam int ALU_F  = 1;
   localparam int ALU_NO = 0;

   typedef struct packed {
      logic                is_load;
      logic [WORD_W-1:0]   load_value;
      logic                use_mem;
      logic [CTRL_W-1:0]   alu_ctrl;
      logic [2:0]          dest;
      logic [2:0]          jump;
      logic [WORD_W-1:0]   mem_read;
   } item_type;

endpackage

>>> hw/rtl/trcs_front.sv
// Front stage: accept a request and decode it into an execution item.
module trcs_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   output logic                        full,
   input  logic [trcs_pkg::WORD_W-1:0] instruction,
   input  logic [trcs_pkg::WORD_W-1:0] mem_read,
   output logic                        item_valid,
   input  logic                        item_ready,
   output trcs_pkg::item_type          item
);

   logic               valid_ff;
   logic               valid_in;
   trcs_pkg::item_type item_ff;
   trcs_pkg::item_type item_in;
   logic               take;

   assign full = valid_ff && !item_ready;
   assign take = push && !full;

   always_comb begin
      item_in            = item_ff;
      valid_in           = valid_ff && !item_ready;
      if (take) begin
         valid_in           = 1'b1;
         item_in.is_load    = !instruction[trcs_pkg::BIT_COMPUTE];
         item_in.load_value = instruction;
         item_in.use_mem    = instruction[trcs_pkg::BIT_USE_MEM];
         item_in.alu_ctrl   = instruction[trcs_pkg::CTRL_LSB +: trcs_pkg::CTRL_W];
         item_in.dest       = instruction[trcs_pkg::DEST_LSB +: 3];
         item_in.jump       = instruction[trcs_pkg::JUMP_LSB +: 3];
         item_in.mem_read   = mem_read;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

>>> hw/rtl/trcs_queue.sv
// Short queue of decoded items between the front and back stages.
`include "two_register_cpu_step_assert.svh"

module trcs_queue #(
   parameter int DEPTH = trcs_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  trcs_pkg::item_type in_item,
   output logic               out_valid,
   input  logic               out_ready,
   output trcs_pkg::item_type out_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   trcs_pkg::item_type     slot_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff;
   logic [PTR_W-1:0]       wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff;
   logic [PTR_W-1:0]       rd_ptr_in;
   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;
   logic                   do_push;
   logic                   do_pop;

   assign in_ready  = count_ff != CNT_W'(DEPTH);
   assign out_valid = count_ff != '0;
   assign do_push   = in_valid && in_ready;
   assign do_pop    = out_valid && out_ready;
   assign out_item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= in_item;
      end
   end

   `TRCS_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH))
   `TRCS_ASSERT_NEXT(a_push_only_grows, clock, reset, do_push && !do_pop, count_ff == $past(count_ff) + CNT_W'(1))

endmodule

>>> hw/rtl/trcs_back.sv
// Back stage: execute items against the A, D and PC registers.
`include "two_register_cpu_step_assert.svh"

module trcs_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        item_valid,
   output logic                        item_ready,
   input  trcs_pkg::item_type          item,
   output logic                        empty,
   input  logic                        pop,
   output logic                        write_mem,
   output logic [trcs_pkg::ADDR_W-1:0] mem_address,
   output logic [trcs_pkg::WORD_W-1:0] mem_value,
   output logic [trcs_pkg::ADDR_W-1:0] next_pc
);

   localparam int W = trcs_pkg::WORD_W;
   localparam int P = trcs_pkg::ADDR_W;

   logic [W-1:0] a_ff, a_in;
   logic [W-1:0] d_ff, d_in;
   logic [P-1:0] pc_ff, pc_in;
   logic         out_valid_ff, out_valid_in;
   logic         out_wr_ff, out_wr_in;
   logic [P-1:0] out_addr_ff, out_addr_in;
   logic [W-1:0] out_value_ff, out_value_in;
   logic [P-1:0] out_pc_ff, out_pc_in;

   logic         fire;
   logic         take;
   logic [W-1:0] x0, x1, y0, y1, r0, result;
   logic         neg, zero, pos;
   logic [P-1:0] pc_step;

   assign item_ready = !out_valid_ff || pop;
   assign fire       = item_valid && item_ready;
   assign pc_step    = pc_ff + P'(1);

   always_comb begin
      x0 = item.alu_ctrl[trcs_pkg::ALU_ZX] ? '0 : d_ff;
      x1 = item.alu_ctrl[trcs_pkg::ALU_NX] ? ~x0 : x0;
      y0 = item.use_mem ? item.mem_read : a_ff;
      y0 = item.alu_ctrl[trcs_pkg::ALU_ZY] ? '0 : y0;
      y1 = item.alu_ctrl[trcs_pkg::ALU_NY] ? ~y0 : y0;
      r0 = item.alu_ctrl[trcs_pkg::ALU_F] ? x1 + y1 : x1 & y1;
      result = item.alu_ctrl[trcs_pkg::ALU_NO] ? ~r0 : r0;
      neg  = result[W-1];
      zero = result == '0;
      pos  = !neg && !zero;
      take = (item.jump[trcs_pkg::JUMP_LT] && neg) ||
             (item.jump[trcs_pkg::JUMP_EQ] && zero) ||
             (item.jump[trcs_pkg::JUMP_GT] && pos);
   end

   always_comb begin
      a_in         = a_ff;
      d_in         = d_ff;
      pc_in        = pc_ff;
      out_valid_in = out_valid_ff && !pop;
      out_wr_in    = out_wr_ff;
      out_addr_in  = out_addr_ff;
      out_value_in = out_value_ff;
      out_pc_in    = out_pc_ff;
      if (fire) begin
         if (item.is_load) begin
            a_in         = item.load_value;
            out_wr_in    = 1'b0;
            out_value_in = '0;
            pc_in        = pc_step;
         end else begin
            if (item.dest[trcs_pkg::DEST_A]) begin
               a_in = result;
            end
            if (item.dest[trcs_pkg::DEST_D]) begin
               d_in = result;
            end
            out_wr_in    = item.dest[trcs_pkg::DEST_M];
            out_value_in = result;
            pc_in        = take ? a_in[P-1:0] : pc_step;
         end
         out_valid_in = 1'b1;
         out_addr_in  = a_in[P-1:0];
         out_pc_in    = pc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff         <= '0;
         d_ff         <= '0;
         pc_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         a_ff         <= a_in;
         d_ff         <= d_in;
         pc_ff        <= pc_in;
         out_valid_ff <= out_valid_in;
      end
      out_wr_ff    <= out_wr_in;
      out_addr_ff  <= out_addr_in;
      out_value_ff <= out_value_in;
      out_pc_ff    <= out_pc_in;
   end

   assign empty       = !out_valid_ff;
   assign write_mem   = out_wr_ff;
   assign mem_address = out_addr_ff;
   assign mem_value   = out_value_ff;
   assign next_pc     = out_pc_ff;

   `TRCS_ASSERT_NEXT(a_load_quiet, clock, reset, fire && item.is_load, !out_wr_ff && out_value_ff == '0)
   `TRCS_ASSERT_NEXT(a_pc_advance, clock, reset, fire && (item.is_load || !take), pc_ff == $past(pc_ff) + P'(1))
   `TRCS_ASSERT_NEXT(a_pc_reported, clock, reset, fire, out_pc_ff == pc_ff && out_addr_ff == a_ff[P-1:0])

endmodule

>>> hw/rtl/two_register_cpu_step.sv
// Top level of the two-register CPU step: front decode, item queue, back execution.
//
// Requests carry one 16-bit instruction and the data word read at the address in A.
// A request is taken on a clock edge with req_push high and req_full low.
// Each request yields exactly one result: write_mem, mem_address, mem_value, next_pc.
// The oldest result sits on the rsp_ ports while rsp_empty is low and leaves on a
// clock edge with rsp_pop high.
// A request passes the decode register and the item queue before the execution
// register loads its result. Throughput: one request per cycle while req_full is low;
// the execution register, which holds A, D and the program counter, retires one
// instruction per clock while rsp_pop is high.
// When rsp_pop stays low the result holds, the back stage stops, the item queue
// fills, and req_full rises once the decode register can no longer drain.
// Synchronous reset clears A, D and the program counter to zero and empties all
// stages; requests are accepted from the first cycle after reset.
module two_register_cpu_step #(
   parameter int QUEUE_DEPTH = trcs_pkg::QUEUE_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic [trcs_pkg::WORD_W-1:0]        req_instruction,
   input  logic signed [trcs_pkg::WORD_W-1:0] req_mem_read,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic                               rsp_write_mem,
   output logic [trcs_pkg::ADDR_W-1:0]        rsp_mem_address,
   output logic signed [trcs_pkg::WORD_W-1:0] rsp_mem_value,
   output logic [trcs_pkg::ADDR_W-1:0]        rsp_next_pc
);

   logic                        front_valid;
   logic                        front_ready;
   trcs_pkg::item_type          front_item;
   logic                        queue_valid;
   logic                        queue_ready;
   trcs_pkg::item_type          queue_item;
   logic [trcs_pkg::WORD_W-1:0] mem_value_raw;

   trcs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (req_push),
      .full        (req_full),
      .instruction (req_instruction),
      .mem_read    ($unsigned(req_mem_read)),
      .item_valid  (front_valid),
      .item_ready  (front_ready),
      .item        (front_item)
   );

   trcs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_item   (front_item),
      .out_valid (queue_valid),
      .out_ready (queue_ready),
      .out_item  (queue_item)
   );

   trcs_back u_back (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (queue_valid),
      .item_ready  (queue_ready),
      .item        (queue_item),
      .empty       (rsp_empty),
      .pop         (rsp_pop),
      .write_mem   (rsp_write_mem),
      .mem_address (rsp_mem_address),
      .mem_value   (mem_value_raw),
      .next_pc     (rsp_next_pc)
   );

   assign rsp_mem_value = $signed(mem_value_raw);

endmodule

>>> tb/tb.sv
// Self-checking testbench for two_register_cpu_step: directed, random and backpressure runs.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import trcs_pkg::*;

   typedef struct packed {
      logic              write_mem;
      logic [ADDR_W-1:0] mem_address;
      logic [WORD_W-1:0] mem_value;
      logic [ADDR_W-1:0] next_pc;
   } cpu_result_type;

   typedef enum {POP_ALWAYS, POP_PATTERN, POP_RANDOM} pop_style_type;

   localparam logic [CTRL_W-1:0] OP_ZERO      = 6'b101010;
   localparam logic [CTRL_W-1:0] OP_ONE       = 6'b111111;
   localparam logic [CTRL_W-1:0] OP_MINUS_ONE = 6'b111010;
   localparam logic [CTRL_W-1:0] OP_X         = 6'b001100;
   localparam logic [CTRL_W-1:0] OP_Y         = 6'b110000;
   localparam logic [CTRL_W-1:0] OP_NOT_X     = 6'b001101;
   localparam logic [CTRL_W-1:0] OP_NEG_Y     = 6'b110011;
   localparam logic [CTRL_W-1:0] OP_X_PLUS_1  = 6'b011111;
   localparam logic [CTRL_W-1:0] OP_X_PLUS_Y  = 6'b000010;
   localparam logic [CTRL_W-1:0] OP_X_MINUS_Y = 6'b010011;
   localparam logic [CTRL_W-1:0] OP_Y_MINUS_X = 6'b000111;
   localparam logic [CTRL_W-1:0] OP_X_AND_Y   = 6'b000000;
   localparam logic [CTRL_W-1:0] OP_X_OR_Y    = 6'b010101;

   localparam logic [2:0] NO_DEST = 3'b000;
   localparam logic [2:0] TO_A    = 3'(1 << DEST_A);
   localparam logic [2:0] TO_D    = 3'(1 << DEST_D);
   localparam logic [2:0] TO_M    = 3'(1 << DEST_M);

   localparam logic [2:0] NO_JUMP = 3'b000;
   localparam logic [2:0] ON_LT   = 3'(1 << JUMP_LT);
   localparam logic [2:0] ON_EQ   = 3'(1 << JUMP_EQ);
   localparam logic [2:0] ON_GT   = 3'(1 << JUMP_GT);
   localparam logic [2:0] ON_ANY  = ON_LT | ON_EQ | ON_GT;

   localparam logic [WORD_W-1:0] UNUSED_BITS = 16'h6000;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_push = 1'b0;
   logic                      req_full;
   logic [WORD_W-1:0]         req_instruction = '0;
   logic signed [WORD_W-1:0]  req_mem_read = '0;
   logic                      rsp_empty;
   logic                      rsp_pop = 1'b0;
   logic                      rsp_write_mem;
   logic [ADDR_W-1:0]         rsp_mem_address;
   logic signed [WORD_W-1:0]  rsp_mem_value;
   logic [ADDR_W-1:0]         rsp_next_pc;

   logic [WORD_W-1:0] cpu_a = '0;
   logic [WORD_W-1:0] cpu_d = '0;
   logic [ADDR_W-1:0] cpu_pc = '0;

   cpu_result_type pending_results[$];
   int             failures = 0;

   pop_style_type pop_style = POP_ALWAYS;
   logic [15:0]   pop_pattern = 16'hFFFF;
   int            hold_off_cycles = 0;
   bit            sender_gaps = 1'b0;
   int            burst_left = 0;

   two_register_cpu_step dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_instruction (req_instruction),
      .req_mem_read    (req_mem_read),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_write_mem   (rsp_write_mem),
      .rsp_mem_address (rsp_mem_address),
      .rsp_mem_value   (rsp_mem_value),
      .rsp_next_pc     (rsp_next_pc)
   );

   always #1 clock = ~clock;

   initial begin
      #400000;
      $display("Regression FAIL");
      $finish;
   end

   function automatic logic [WORD_W-1:0] compute_word(input logic use_mem,
                                                      input logic [CTRL_W-1:0] ctrl,
                                                      input logic [2:0] dest,
                                                      input logic [2:0] jump);
      logic [WORD_W-1:0] w;
      w = UNUSED_BITS;
      w[BIT_COMPUTE] = 1'b1;
      w[BIT_USE_MEM] = use_mem;
      w[CTRL_LSB +: CTRL_W] = ctrl;
      w[DEST_LSB +: 3] = dest;
      w[JUMP_LSB +: 3] = jump;
      return w;
   endfunction

   function automatic cpu_result_type execute_instruction(input logic [WORD_W-1:0] instr,
                                                          input logic [WORD_W-1:0] mrd);
      cpu_result_type    r;
      logic [WORD_W-1:0] x;
      logic [WORD_W-1:0] y;
      logic [WORD_W-1:0] alu_out;
      logic [CTRL_W-1:0] ctrl;
      logic [2:0]        dest;
      logic [2:0]        jump;
      logic              taken;
      alu_out = '0;
      r.write_mem = 1'b0;
      r.next_pc = cpu_pc + 1'b1;
      if (!instr[BIT_COMPUTE]) begin
         cpu_a = instr;
      end else begin
         ctrl = instr[CTRL_LSB +: CTRL_W];
         dest = instr[DEST_LSB +: 3];
         jump = instr[JUMP_LSB +: 3];
         x = cpu_d;
         y = instr[BIT_USE_MEM] ? mrd : cpu_a;
         if (ctrl[ALU_ZX]) x = '0;
         if (ctrl[ALU_NX]) x = ~x;
         if (ctrl[ALU_ZY]) y = '0;
         if (ctrl[ALU_NY]) y = ~y;
         alu_out = ctrl[ALU_F] ? x + y : x & y;
         if (ctrl[ALU_NO]) alu_out = ~alu_out;
         if (dest[DEST_A]) cpu_a = alu_out;
         if (dest[DEST_D]) cpu_d = alu_out;
         r.write_mem = dest[DEST_M];
         taken = (jump[JUMP_LT] && alu_out[WORD_W-1]) ||
                 (jump[JUMP_EQ] && alu_out == '0) ||
                 (jump[JUMP_GT] && !alu_out[WORD_W-1] && alu_out != '0);
         if (taken) r.next_pc = cpu_a[ADDR_W-1:0];
      end
      cpu_pc = r.next_pc;
      r.mem_address = cpu_a[ADDR_W-1:0];
      r.mem_value = alu_out;
      return r;
   endfunction

   task automatic check_result();
      cpu_result_type exp_r;
      if (pending_results.size() == 0) begin
         $display("%0t: unexpected result wm=%0b addr=%h val=%h pc=%h", $time,
                  rsp_write_mem, rsp_mem_address, rsp_mem_value, rsp_next_pc);
         failures++;
         return;
      end
      exp_r = pending_results.pop_front();
      if (rsp_write_mem !== exp_r.write_mem) begin
         $display("%0t: write_mem expected %0b actual %0b", $time,
                  exp_r.write_mem, rsp_write_mem);
         failures++;
      end
      if (rsp_mem_address !== exp_r.mem_address) begin
         $display("%0t: mem_address expected %h actual %h", $time,
                  exp_r.mem_address, rsp_mem_address);
         failures++;
      end
      if (rsp_mem_value !== exp_r.mem_value) begin
         $display("%0t: mem_value expected %h actual %h", $time,
                  exp_r.mem_value, rsp_mem_value);
         failures++;
      end
      if (rsp_next_pc !== exp_r.next_pc) begin
         $display("%0t: next_pc expected %h actual %h", $time,
                  exp_r.next_pc, rsp_next_pc);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) check_result();
         pop_pattern = {pop_pattern[0], pop_pattern[15:1]};
         if (hold_off_cycles > 0) begin
            hold_off_cycles = hold_off_cycles - 1;
            rsp_pop <= 1'b0;
         end else begin
            case (pop_style)
               POP_ALWAYS:  rsp_pop <= 1'b1;
               POP_PATTERN: rsp_pop <= pop_pattern[0];
               default:     rsp_pop <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   task automatic send_request(input logic [WORD_W-1:0] instr, input logic [WORD_W-1:0] mrd);
      if (sender_gaps && burst_left == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      if (burst_left > 0) burst_left--;
      req_push <= 1'b1;
      req_instruction <= instr;
      req_mem_read <= mrd;
      @(posedge clock);
      while (req_full) @(posedge clock);
      pending_results.push_back(execute_instruction(instr, mrd));
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic [WORD_W-1:0] random_mem_word();
      case ($urandom_range(0, 7))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         3:       return 16'hFFFF;
         default: return WORD_W'($urandom);
      endcase
   endfunction

   function automatic logic [WORD_W-1:0] random_instruction();
      if ($urandom_range(0, 9) < 3) return {1'b0, 15'($urandom)};
      return {1'b1, 15'($urandom)};
   endfunction

   task automatic run_random(input int count, input pop_style_type style, input bit gaps);
      pop_style = style;
      pop_pattern = 16'($urandom) | 16'h0001;
      sender_gaps = gaps;
      burst_left = 0;
      repeat (count) send_request(random_instruction(), random_mem_word());
   endtask

   task automatic test_directed();
      pop_style = POP_ALWAYS;
      sender_gaps = 1'b0;
      send_request(16'h0000, 16'h1111);
      send_request(16'h7FFF, 16'h2222);
      send_request(compute_word(1'b1, OP_Y, TO_D, NO_JUMP), 16'h8000);
      send_request(compute_word(1'b0, OP_X, TO_M, NO_JUMP), 16'h0000);
      send_request(compute_word(1'b1, OP_X_PLUS_Y, TO_D, NO_JUMP), 16'h7FFF);
      send_request(compute_word(1'b0, OP_X, NO_DEST, ON_LT), 16'h0000);
      send_request(16'h1234, 16'hFFFF);
      send_request(compute_word(1'b0, OP_MINUS_ONE, TO_A | TO_D | TO_M, ON_ANY), 16'h0000);
      send_request(compute_word(1'b0, OP_X_PLUS_1, TO_D, ON_EQ), 16'h0000);
      send_request(compute_word(1'b0, OP_ZERO, NO_DEST, ON_GT), 16'h0000);
      send_request(compute_word(1'b0, OP_ZERO, NO_DEST, ON_ANY) ^ UNUSED_BITS, 16'h0000);
      send_request(compute_word(1'b0, OP_ONE, TO_D, ON_GT), 16'h0000);
      send_request(16'h0005, 16'h0000);
      send_request(compute_word(1'b1, OP_X_PLUS_Y, TO_A | TO_M, ON_EQ | ON_GT), 16'h7FFF);
      send_request(compute_word(1'b1, OP_Y, TO_D, ON_LT | ON_GT), 16'hFFFF);
      send_request(compute_word(1'b0, OP_NOT_X, TO_M, NO_JUMP), 16'h0000);
      send_request(compute_word(1'b0, OP_NEG_Y, TO_A, NO_JUMP), 16'h0000);
      send_request(compute_word(1'b0, OP_X_OR_Y, TO_D, ON_LT | ON_EQ), 16'h0000);
      send_request(compute_word(1'b1, OP_X_AND_Y, TO_D | TO_M, NO_JUMP), 16'hAAAA);
      send_request(compute_word(1'b1, OP_X_MINUS_Y, TO_A, ON_LT), 16'h5555);
      send_request(compute_word(1'b1, OP_Y_MINUS_X, TO_A | TO_D, ON_ANY), 16'h8000);
      wait_drained();
   endtask

   task automatic test_random_gappy();
      run_random(900, POP_RANDOM, 1'b1);
      wait_drained();
   endtask

   task automatic test_random_patterned();
      run_random(250, POP_PATTERN, 1'b1);
      wait_drained();
   endtask

   task automatic test_backpressure();
      pop_style = POP_ALWAYS;
      hold_off_cycles = 200;
      run_random(40, POP_ALWAYS, 1'b0);
      wait_drained();
   endtask

   task automatic test_full_rate();
      run_random(200, POP_ALWAYS, 1'b0);
      wait_drained();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_gappy();
      test_backpressure();
      test_random_patterned();
      test_full_rate();
      wait_drained();
      repeat (8) @(posedge clock);
      if (failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule

>>> two_register_cpu_step.f
+incdir+hw/rtl
hw/rtl/trcs_pkg.sv
hw/rtl/trcs_front.sv
hw/rtl/trcs_queue.sv
hw/rtl/trcs_back.sv
hw/rtl/two_register_cpu_step.sv
tb/tb.sv
